// File: design/osws_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// osws_pkg
// Shared types, constants and the control store for the one-shot wavetable
// sampler.
// ----------------------------------------------------------------------------
package osws_pkg;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    localparam int MUL_A_W = 26;
    localparam int MUL_B_W = 25;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = PROD_W + 2;
    localparam int FRAC_W  = 24;

    localparam int STEP_W    = 4;
    localparam int UCODE_LEN = 12;
    localparam logic [STEP_W-1:0] STEP_HOME = STEP_W'(0);
    localparam logic [STEP_W-1:0] STEP_BODY = STEP_W'(1);

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_START = 2'd1,
        ACT_STOP  = 2'd2,
        ACT_LOAD  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        REG_PHASE_INCREMENT = 3'd0,
        REG_OUTPUT_LEVEL    = 3'd1,
        REG_WAVE_SELECT     = 3'd2,
        REG_COEF_B0         = 3'd3,
        REG_COEF_B1         = 3'd4,
        REG_COEF_B2         = 3'd5,
        REG_COEF_A1         = 3'd6,
        REG_COEF_A2         = 3'd7
    } reg_index_t;

    typedef enum logic [1:0] {
        A_PHASE = 2'd0,
        A_DIFF  = 2'd1,
        A_X     = 2'd2,
        A_Y     = 2'd3
    } a_sel_t;

    typedef enum logic [2:0] {
        B_TSM1  = 3'd0,
        B_FRAC  = 3'd1,
        B_B0    = 3'd2,
        B_B1    = 3'd3,
        B_B2    = 3'd4,
        B_A1    = 3'd5,
        B_A2    = 3'd6,
        B_LEVEL = 3'd7
    } b_sel_t;

    typedef enum logic [3:0] {
        OP_NOP        = 4'd0,
        OP_INDEX      = 4'd1,
        OP_SAMPLE0    = 4'd2,
        OP_INTERP     = 4'd3,
        OP_FILTER_OUT = 4'd4,
        OP_ACC_LOAD   = 4'd5,
        OP_ACC_SUB    = 4'd6,
        OP_DELAY1     = 4'd7,
        OP_DELAY2     = 4'd8
    } op_t;

    typedef enum logic [1:0] {
        J_NEXT = 2'd0,
        J_WAIT = 2'd1,
        J_HOME = 2'd2
    } jump_t;

    typedef struct packed {
        a_sel_t a_sel;
        b_sel_t b_sel;
        op_t    op;
        jump_t  jump;
    } ctrl_t;

    // Every step loads the product register; a step consumes the product
    // that the step before it started.
    localparam ctrl_t UCODE [UCODE_LEN] = '{
        '{A_PHASE, B_TSM1,  OP_NOP,        J_WAIT},
        '{A_X,     B_B0,    OP_INDEX,      J_NEXT},
        '{A_X,     B_B0,    OP_SAMPLE0,    J_NEXT},
        '{A_DIFF,  B_FRAC,  OP_NOP,        J_NEXT},
        '{A_X,     B_B0,    OP_INTERP,     J_NEXT},
        '{A_X,     B_B0,    OP_NOP,        J_NEXT},
        '{A_X,     B_B1,    OP_FILTER_OUT, J_NEXT},
        '{A_Y,     B_A1,    OP_ACC_LOAD,   J_NEXT},
        '{A_X,     B_B2,    OP_ACC_SUB,    J_NEXT},
        '{A_Y,     B_A2,    OP_DELAY1,     J_NEXT},
        '{A_Y,     B_LEVEL, OP_DELAY2,     J_NEXT},
        '{A_X,     B_B0,    OP_NOP,        J_HOME}
    };

endpackage
`default_nettype wire

// File: design/osws_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// osws_in_if
// Input channel of the sampler: one action per transaction.
// ----------------------------------------------------------------------------
interface osws_in_if;
    import osws_pkg::*;

    logic               valid;
    logic               ready;
    action_t            action;
    logic [11:0]        table_address;
    logic signed [15:0] table_data;

    modport source (output valid, action, table_address, table_data, input ready);
    modport sink   (input valid, action, table_address, table_data, output ready);
endinterface
`default_nettype wire

// File: design/osws_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// osws_out_if
// Output channel of the sampler: one result per transaction.
// ----------------------------------------------------------------------------
interface osws_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample_out;
    logic               running;

    modport source (output valid, sample_out, running, input ready);
    modport sink   (input valid, sample_out, running, output ready);
endinterface
`default_nettype wire

// File: design/one_shot_wavetable_sampler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// one_shot_wavetable_sampler
// One-shot wavetable player with linear interpolation, biquad filter and
// output gain, run by a small microcoded sequencer over one multiplier.
// ----------------------------------------------------------------------------
//  Channel   Kind           Transaction
//  in_ch     valid/ready    one action: tick, start, stop or load
//  out_ch    valid/ready    one sample_out and running flag per input
//  apb       APB write/read configuration registers at byte address 4*i
//
//  A tick while playing runs eleven program steps that share one 26x25
//  multiplier for eight products.
//  Start, stop, load and a tick while stopped give their result in the next cycle.
//  Reset initialises the control state, the phase, the filter and the registers but
//  not the wave store. No input is taken while the program runs or while a
//  result waits on a stalled output.
// ----------------------------------------------------------------------------
module one_shot_wavetable_sampler #(
    parameter int TABLE_SIZE  = 1024,
    parameter int NUM_WAVES   = 4,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    osws_in_if.sink                            in_ch,
    osws_out_if.source                         out_ch,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [osws_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [osws_pkg::PDATA_W-1:0]  pwdata,
    output logic      [osws_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready
);
    import osws_pkg::*;

    localparam int STORE_DEPTH = NUM_WAVES * TABLE_SIZE;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int IDX_W       = $clog2(TABLE_SIZE);
    localparam int IDXF_W      = PROD_W - FRAC_W;
    localparam int DELAY_W     = SAMPLE_BITS + 24;

    localparam logic [IDXF_W-1:0] IDX_LIM = IDXF_W'(TABLE_SIZE - 1);

    localparam logic [STORE_AW-1:0] WAVE_BASE [4] = '{
        STORE_AW'((0 % NUM_WAVES) * TABLE_SIZE),
        STORE_AW'((1 % NUM_WAVES) * TABLE_SIZE),
        STORE_AW'((2 % NUM_WAVES) * TABLE_SIZE),
        STORE_AW'((3 % NUM_WAVES) * TABLE_SIZE)
    };

    localparam logic signed [ACC_W-1:0] SAMPLE_MAX =
        (ACC_W'(1) <<< (SAMPLE_BITS - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] SAMPLE_MIN = -SAMPLE_MAX - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] DELAY_MAX  =
        (ACC_W'(1) <<< (DELAY_W - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] DELAY_MIN  = -DELAY_MAX - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] ROUND_Y    = ACC_W'(1) <<< 19;
    localparam logic signed [ACC_W-1:0] ROUND_OUT  = ACC_W'(1) <<< 13;

    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
        input logic signed [ACC_W-1:0] v
    );
        logic signed [SAMPLE_BITS-1:0] r;
        if (v > SAMPLE_MAX)
        begin
            r = SAMPLE_MAX[SAMPLE_BITS-1:0];
        end
        else if (v < SAMPLE_MIN)
        begin
            r = SAMPLE_MIN[SAMPLE_BITS-1:0];
        end
        else
        begin
            r = v[SAMPLE_BITS-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [DELAY_W-1:0] sat_delay(
        input logic signed [ACC_W-1:0] v
    );
        logic signed [DELAY_W-1:0] r;
        if (v > DELAY_MAX)
        begin
            r = DELAY_MAX[DELAY_W-1:0];
        end
        else if (v < DELAY_MIN)
        begin
            r = DELAY_MIN[DELAY_W-1:0];
        end
        else
        begin
            r = v[DELAY_W-1:0];
        end
        return r;
    endfunction

    // Configuration registers.
    logic [23:0]        phase_increment_reg;
    logic [15:0]        output_level_reg;
    logic [1:0]         wave_select_reg;
    logic signed [23:0] coef_b0_reg;
    logic signed [23:0] coef_b1_reg;
    logic signed [23:0] coef_b2_reg;
    logic signed [23:0] coef_a1_reg;
    logic signed [23:0] coef_a2_reg;

    // Control state.
    logic [STEP_W-1:0] step_reg, step_next;
    logic [24:0]       phase_reg, phase_next;
    logic              playing_reg, playing_next;
    logic              out_valid_reg, out_valid_next;
    logic signed [15:0] sample_out_reg;
    logic              running_reg;

    // Datapath registers.
    logic signed [DELAY_W-1:0]     d1_reg;
    logic signed [DELAY_W-1:0]     d2_reg;
    logic signed [ACC_W-1:0]       acc_reg;
    logic [FRAC_W-1:0]             frac_reg;
    logic [IDX_W-1:0]              i1_reg;
    logic signed [15:0]            s0_reg;
    logic signed [15:0]            x_reg;
    logic signed [SAMPLE_BITS-1:0] y_reg;
    logic signed [15:0]            rdata_reg;
    logic signed [15:0]            wave_mem [STORE_DEPTH];

    ctrl_t                     cw;
    logic                      cfg_write;
    reg_index_t                cfg_index;
    logic                      in_fire;
    logic                      start_fire;
    logic                      load_ok;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic signed [ACC_W-1:0]   prod_ext;
    logic signed [PROD_W-1:0]  interp_shift;
    logic signed [ACC_W-1:0]   y_shift;
    logic signed [ACC_W-1:0]   out_shift;
    logic signed [16:0]        diff;
    logic [IDXF_W-1:0]         idx_full;
    logic [IDXF_W-1:0]         idx_inc;
    logic [IDX_W-1:0]          i0;
    logic [IDX_W-1:0]          i1;
    logic [STORE_AW-1:0]       wave_base;
    logic [STORE_AW-1:0]       rd_addr;
    logic [24:0]               phase_sum;
    logic                      out_set;
    logic signed [15:0]        out_sample;
    logic                      out_running;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = reg_index_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_increment_reg <= '0;
            output_level_reg    <= 16'd16384;
            wave_select_reg     <= '0;
            coef_b0_reg         <= '0;
            coef_b1_reg         <= '0;
            coef_b2_reg         <= '0;
            coef_a1_reg         <= '0;
            coef_a2_reg         <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_PHASE_INCREMENT: phase_increment_reg <= pwdata[23:0];
                REG_OUTPUT_LEVEL:    output_level_reg    <= pwdata[15:0];
                REG_WAVE_SELECT:     wave_select_reg     <= pwdata[1:0];
                REG_COEF_B0:         coef_b0_reg         <= pwdata[23:0];
                REG_COEF_B1:         coef_b1_reg         <= pwdata[23:0];
                REG_COEF_B2:         coef_b2_reg         <= pwdata[23:0];
                REG_COEF_A1:         coef_a1_reg         <= pwdata[23:0];
                REG_COEF_A2:         coef_a2_reg         <= pwdata[23:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            REG_PHASE_INCREMENT: prdata = PDATA_W'(phase_increment_reg);
            REG_OUTPUT_LEVEL:    prdata = PDATA_W'(output_level_reg);
            REG_WAVE_SELECT:     prdata = PDATA_W'(wave_select_reg);
            REG_COEF_B0:         prdata = PDATA_W'({coef_b0_reg});
            REG_COEF_B1:         prdata = PDATA_W'({coef_b1_reg});
            REG_COEF_B2:         prdata = PDATA_W'({coef_b2_reg});
            REG_COEF_A1:         prdata = PDATA_W'({coef_a1_reg});
            REG_COEF_A2:         prdata = PDATA_W'({coef_a2_reg});
            default:             prdata = '0;
        endcase
    end

    // Sequencer.
    assign cw          = UCODE[step_reg];
    assign in_ch.ready = (step_reg == STEP_HOME) && (!out_valid_reg || out_ch.ready);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign start_fire  = in_fire && (in_ch.action == ACT_START);
    assign load_ok     = 32'(in_ch.table_address) < 32'(STORE_DEPTH);
    assign phase_sum   = phase_reg + {1'b0, phase_increment_reg};

    always_comb
    begin
        step_next    = step_reg;
        phase_next   = phase_reg;
        playing_next = playing_reg;
        out_set      = 1'b0;
        out_sample   = '0;
        out_running  = playing_reg;
        case (cw.jump)
            J_WAIT:
            begin
                if (in_fire)
                begin
                    case (in_ch.action)
                        ACT_TICK:
                        begin
                            if (playing_reg)
                            begin
                                step_next = STEP_BODY;
                            end
                            else
                            begin
                                out_set = 1'b1;
                            end
                        end
                        ACT_START:
                        begin
                            phase_next   = '0;
                            playing_next = 1'b1;
                            out_set      = 1'b1;
                            out_running  = 1'b1;
                        end
                        ACT_STOP:
                        begin
                            phase_next   = '0;
                            playing_next = 1'b0;
                            out_set      = 1'b1;
                            out_running  = 1'b0;
                        end
                        ACT_LOAD:
                        begin
                            out_set = 1'b1;
                        end
                        default:
                        begin
                            out_set = 1'b1;
                        end
                    endcase
                end
            end
            J_NEXT:
            begin
                step_next = step_reg + STEP_W'(1);
            end
            J_HOME:
            begin
                step_next    = STEP_HOME;
                phase_next   = phase_sum;
                playing_next = !phase_sum[24];
                out_set      = 1'b1;
                out_sample   = 16'(sat_sample(out_shift));
                out_running  = !phase_sum[24];
            end
            default:
            begin
                step_next = STEP_HOME;
            end
        endcase
        out_valid_next = out_set || (out_valid_reg && !out_ch.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_HOME;
            phase_reg     <= '0;
            playing_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            phase_reg     <= phase_next;
            playing_reg   <= playing_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_set)
        begin
            sample_out_reg <= out_sample;
            running_reg    <= out_running;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.sample_out = sample_out_reg;
    assign out_ch.running    = running_reg;

    // Multiplier operands.
    assign diff = 17'(rdata_reg) - 17'(s0_reg);

    always_comb
    begin
        case (cw.a_sel)
            A_PHASE: mul_a = MUL_A_W'({1'b0, phase_reg});
            A_DIFF:  mul_a = MUL_A_W'(diff);
            A_X:     mul_a = MUL_A_W'(x_reg);
            A_Y:     mul_a = MUL_A_W'(y_reg);
            default: mul_a = '0;
        endcase
    end

    always_comb
    begin
        case (cw.b_sel)
            B_TSM1:  mul_b = MUL_B_W'(TABLE_SIZE - 1);
            B_FRAC:  mul_b = MUL_B_W'({1'b0, frac_reg});
            B_B0:    mul_b = MUL_B_W'(coef_b0_reg);
            B_B1:    mul_b = MUL_B_W'(coef_b1_reg);
            B_B2:    mul_b = MUL_B_W'(coef_b2_reg);
            B_A1:    mul_b = MUL_B_W'(coef_a1_reg);
            B_A2:    mul_b = MUL_B_W'(coef_a2_reg);
            B_LEVEL: mul_b = MUL_B_W'({1'b0, output_level_reg});
            default: mul_b = '0;
        endcase
    end

    osws_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // Table index, interpolation and filter arithmetic.
    assign prod_ext     = ACC_W'(prod);
    assign interp_shift = prod >>> FRAC_W;
    assign y_shift      = (prod_ext + ACC_W'(d1_reg) + ROUND_Y) >>> 20;
    assign out_shift    = (prod_ext + ROUND_OUT) >>> 14;

    assign idx_full  = prod[PROD_W-1:FRAC_W];
    assign idx_inc   = idx_full + IDXF_W'(1);
    assign i0        = IDX_W'((idx_full > IDX_LIM) ? IDX_LIM : idx_full);
    assign i1        = IDX_W'((idx_inc > IDX_LIM) ? IDX_LIM : idx_inc);
    assign wave_base = WAVE_BASE[wave_select_reg];
    assign rd_addr   = wave_base + STORE_AW'((cw.op == OP_INDEX) ? i0 : i1_reg);

    always_ff @(posedge clk)
    begin
        case (cw.op)
            OP_INDEX:
            begin
                frac_reg <= prod[FRAC_W-1:0];
                i1_reg   <= i1;
            end
            OP_SAMPLE0:    s0_reg  <= rdata_reg;
            OP_INTERP:     x_reg   <= s0_reg + interp_shift[15:0];
            OP_FILTER_OUT: y_reg   <= sat_sample(y_shift);
            OP_ACC_LOAD:   acc_reg <= prod_ext;
            OP_ACC_SUB:    acc_reg <= acc_reg - prod_ext;
            OP_DELAY1:     acc_reg <= prod_ext;
            default:       ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1_reg <= '0;
            d2_reg <= '0;
        end
        else if (start_fire)
        begin
            d1_reg <= '0;
            d2_reg <= '0;
        end
        else if (cw.op == OP_DELAY1)
        begin
            d1_reg <= sat_delay(acc_reg + ACC_W'(d2_reg));
        end
        else if (cw.op == OP_DELAY2)
        begin
            d2_reg <= sat_delay(acc_reg - prod_ext);
        end
    end

    // Wave store: one write port for loads, one registered read port.
    always_ff @(posedge clk)
    begin
        if (in_fire && (in_ch.action == ACT_LOAD) && load_ok)
        begin
            wave_mem[STORE_AW'(in_ch.table_address)] <= in_ch.table_data;
        end
        rdata_reg <= wave_mem[rd_addr];
    end
endmodule
`default_nettype wire

// File: design/osws_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// osws_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module osws_mul (
    input  wire logic                                 clk,
    input  wire logic signed [osws_pkg::MUL_A_W-1:0]  a,
    input  wire logic signed [osws_pkg::MUL_B_W-1:0]  b,
    output logic signed      [osws_pkg::PROD_W-1:0]   prod
);
    import osws_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign prod = prod_reg;
endmodule
`default_nettype wire
